FILE: sv/sparse_table_range_min_top_defines.svh
// Assertion macros used by the range-minimum engine's controller, strmq_ctrl.
`ifndef SPARSE_TABLE_RANGE_MIN_TOP_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled during reset.
`define STRMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk and disabled during reset.
`define STRMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STRMQ_ASSERT_IMP(lbl, ante, cons, msg)
`define STRMQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/strmq_pkg.sv
// Types and constants shared by the range-minimum engine modules.
`default_nettype none

package strmq_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int START_W  = 10;
  localparam int END_W    = 11;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_PAST  = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic simple;
    logic app_base;
    logic app_lvl;
    logic app_done;
    logic q_rd0;
    logic q_rd1;
    logic q_cmp;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_append;
    logic need_query;
    logic more;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/sparse_table_range_min_top.sv
// Append: after the capture and decode steps, L = min(LEVELS, floor(log2(p + 1)) + 1) levels
// are built for position p, one level per cycle through the single table RAM write port.
// Query steps: capture, decode, two table reads, compare. Clear or error: capture and decode.
// The result item is valid on the cycle after the last step and waits in an output register.
// Reset clears the loaded count and the control state; table contents are left as they are.
`default_nettype none

module sparse_table_range_min_top
  import strmq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int LEVELS   = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [OPCODE_W-1:0] in_opcode,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  input  wire logic        [START_W-1:0]  in_range_start,
  input  wire logic        [END_W-1:0]    in_range_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [VALUE_W-1:0]  out_min_value,
  output logic             [POS_W-1:0]    out_min_position,
  output logic             [STATUS_W-1:0] out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  strmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  strmq_dp #(
    .CAPACITY (CAPACITY),
    .LEVELS   (LEVELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .cmd              (cmd),
    .sts              (sts),
    .out_min_value    (out_min_value),
    .out_min_position (out_min_position),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

FILE: sv/strmq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module strmq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 11264
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/strmq_ctrl.sv
// Controller state machine that sequences appends, queries and the output item.
`default_nettype none
`include "sparse_table_range_min_top_defines.svh"

module strmq_ctrl
  import strmq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APP_BASE,
    S_APP_LVL,
    S_Q_RD0,
    S_Q_RD1,
    S_Q_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_any;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        // Work starts only once the output register is free to take the result.
        if (!out_valid_r || out_ready) begin
          priority if (sts.need_append) begin
            state_nxt = S_APP_BASE;
          end else if (sts.need_query) begin
            state_nxt = S_Q_RD0;
          end else begin
            cmd.simple = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_APP_BASE: begin
        cmd.app_base = 1'b1;
        cmd.app_done = !sts.more;
        state_nxt    = sts.more ? S_APP_LVL : S_IDLE;
      end
      S_APP_LVL: begin
        cmd.app_lvl  = 1'b1;
        cmd.app_done = !sts.more;
        state_nxt    = sts.more ? S_APP_LVL : S_IDLE;
      end
      S_Q_RD0: begin
        cmd.q_rd0 = 1'b1;
        state_nxt = S_Q_RD1;
      end
      S_Q_RD1: begin
        cmd.q_rd1 = 1'b1;
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign load_any = cmd.simple || cmd.app_done || cmd.q_cmp;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_any) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `STRMQ_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
  `STRMQ_ASSERT_IMP(a_load_free, load_any, !out_valid_r || out_ready, "result overwrote item")
  `STRMQ_ASSERT_IMP(a_out_from_load, $rose(out_valid_r), $past(load_any), "valid without load")

endmodule

`default_nettype wire

FILE: sv/strmq_dp.sv
// Datapath: item registers, loaded count, level builder, query compare and table RAM.
`default_nettype none

module strmq_dp
  import strmq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int LEVELS   = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic        [OPCODE_W-1:0] in_opcode,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  input  wire logic        [START_W-1:0]  in_range_start,
  input  wire logic        [END_W-1:0]    in_range_end,
  input  wire dp_cmd_t                    cmd,
  output dp_sts_t                         sts,
  output logic signed      [VALUE_W-1:0]  out_min_value,
  output logic             [POS_W-1:0]    out_min_position,
  output logic             [STATUS_W-1:0] out_status
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int MEM_AW = $clog2(LEVELS * CAPACITY);
  localparam int ENT_W  = VALUE_W + IDX_W;
  localparam int AW0    = (CNT_W > END_W) ? CNT_W : END_W;
  localparam int AW     = (AW0 > LEVELS + 1) ? AW0 : LEVELS + 1;

  logic        [OPCODE_W-1:0] op_r;
  logic signed [VALUE_W-1:0]  val_r;
  logic        [START_W-1:0]  a_r;
  logic        [END_W-1:0]    b_r;
  logic        [CNT_W-1:0]    cnt_r;
  logic        [LVL_W-1:0]    lvl_r;
  logic signed [VALUE_W-1:0]  run_val_r;
  logic        [IDX_W-1:0]    run_pos_r;
  logic signed [VALUE_W-1:0]  out_val_r;
  logic        [IDX_W-1:0]    out_pos_r;
  status_t                    out_st_r;

  logic        [AW-1:0]       p1, nxt_lvl, span_cur, span_nxt;
  logic        [IDX_W-1:0]    wj, rj_app, j2;
  logic        [END_W-1:0]    len;
  logic        [4:0]          qlvl_raw;
  logic        [LVL_W-1:0]    qlvl;
  logic                       more;
  status_t                    simple_st;

  logic                       mem_we;
  logic        [MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic        [ENT_W-1:0]    mem_wdata, mem_rdata;
  logic signed [VALUE_W-1:0]  rd_val, pick_val;
  logic        [IDX_W-1:0]    rd_pos, pick_pos;
  logic                       take_rd;

  function automatic logic [MEM_AW-1:0] mem_addr(logic [LVL_W-1:0] row, logic [IDX_W-1:0] j);
    return MEM_AW'(row) * MEM_AW'(CAPACITY) + MEM_AW'(j);
  endfunction

  // True when entry (nv, np) beats (ov, oq): smaller value, then lower position.
  function automatic logic better(logic signed [VALUE_W-1:0] nv, logic [IDX_W-1:0] np,
                                  logic signed [VALUE_W-1:0] ov, logic [IDX_W-1:0] oq);
    return (nv < ov) || ((nv == ov) && (np < oq));
  endfunction

  // Level k of position p sits at j = p + 1 - 2^k; its upper half is the entry
  // just written one level down, so each level needs only one RAM read.
  assign p1       = AW'(cnt_r) + AW'(1);
  assign nxt_lvl  = AW'(lvl_r) + AW'(1);
  assign span_cur = AW'(1) << lvl_r;
  assign span_nxt = AW'(1) << nxt_lvl;
  assign more     = (nxt_lvl < AW'(LEVELS)) && (span_nxt <= p1);
  assign wj       = IDX_W'(p1 - span_cur);
  assign rj_app   = IDX_W'(p1 - span_nxt);

  assign len = b_r - END_W'(a_r);

  always_comb begin
    qlvl_raw = '0;
    for (int i = 0; i < END_W; i++) begin
      if (len[i]) begin
        qlvl_raw = 5'(i);
      end
    end
    if (qlvl_raw > 5'(LEVELS - 1)) begin
      qlvl_raw = 5'(LEVELS - 1);
    end
  end

  assign qlvl = LVL_W'(qlvl_raw);
  assign j2   = IDX_W'(AW'(b_r) - (AW'(1) << qlvl));

  assign sts.need_append = (op_r == OP_APPEND) && (AW'(cnt_r) < AW'(CAPACITY));
  assign sts.need_query  = (op_r == OP_QUERY) && (END_W'(a_r) < b_r) &&
                           (AW'(b_r) <= AW'(cnt_r));
  assign sts.more        = more;

  always_comb begin
    priority if (op_r == OP_APPEND) begin
      simple_st = STS_FULL;
    end else if (op_r == OP_QUERY) begin
      simple_st = (END_W'(a_r) >= b_r) ? STS_EMPTY : STS_PAST;
    end else begin
      simple_st = STS_OK;
    end
  end

  assign rd_val   = mem_rdata[ENT_W-1 -: VALUE_W];
  assign rd_pos   = mem_rdata[IDX_W-1:0];
  assign take_rd  = better(rd_val, rd_pos, run_val_r, run_pos_r);
  assign pick_val = take_rd ? rd_val : run_val_r;
  assign pick_pos = take_rd ? rd_pos : run_pos_r;

  assign mem_we    = cmd.app_base || cmd.app_lvl;
  assign mem_waddr = mem_addr(lvl_r, wj);
  assign mem_wdata = cmd.app_base ? {val_r, IDX_W'(cnt_r)} : {pick_val, pick_pos};

  always_comb begin
    priority if (cmd.q_rd0) begin
      mem_raddr = mem_addr(qlvl, IDX_W'(a_r));
    end else if (cmd.q_rd1) begin
      mem_raddr = mem_addr(qlvl, j2);
    end else begin
      mem_raddr = mem_addr(lvl_r, rj_app);
    end
  end

  strmq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LEVELS * CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lvl_r <= '0;
    end else begin
      if (cmd.capture) begin
        lvl_r <= '0;
      end else if (mem_we && more) begin
        lvl_r <= LVL_W'(nxt_lvl);
      end
      if (cmd.simple && (op_r == OP_CLEAR)) begin
        cnt_r <= '0;
      end else if (cmd.app_done) begin
        cnt_r <= CNT_W'(p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_value;
      a_r   <= in_range_start;
      b_r   <= in_range_end;
    end
    if (cmd.app_base) begin
      run_val_r <= val_r;
      run_pos_r <= IDX_W'(cnt_r);
    end else if (cmd.app_lvl) begin
      run_val_r <= pick_val;
      run_pos_r <= pick_pos;
    end else if (cmd.q_rd1) begin
      run_val_r <= rd_val;
      run_pos_r <= rd_pos;
    end
    if (cmd.simple) begin
      out_val_r <= '0;
      out_pos_r <= '0;
      out_st_r  <= simple_st;
    end else if (cmd.app_done) begin
      out_val_r <= '0;
      out_pos_r <= '0;
      out_st_r  <= STS_OK;
    end else if (cmd.q_cmp) begin
      out_val_r <= pick_val;
      out_pos_r <= pick_pos;
      out_st_r  <= STS_OK;
    end
  end

  assign out_min_value    = out_val_r;
  assign out_min_position = POS_W'(out_pos_r);
  assign out_status       = out_st_r;

endmodule

`default_nettype wire

FILE: tb/sv/rmq_checker.sv
// Checker for the range-minimum engine: predicts every answer and compares it with the block.
`timescale 1ns / 100ps

module rmq_checker
  import strmq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int LEVELS   = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic        [OPCODE_W-1:0] in_opcode,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic        [START_W-1:0]  in_range_start,
  input  logic        [END_W-1:0]    in_range_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [VALUE_W-1:0]  out_min_value,
  input  logic        [POS_W-1:0]    out_min_position,
  input  logic        [STATUS_W-1:0] out_status,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic        [POS_W-1:0]   position;
    status_t                   status;
  } answer_t;

  // Entry j of level k holds the minimum of positions [j, j + 2^k) and where it sits.
  logic signed [VALUE_W-1:0] blk_min [LEVELS][CAPACITY];
  logic        [POS_W-1:0]   blk_pos [LEVELS][CAPACITY];
  int                        loaded = 0;

  answer_t answers_due[$];
  int      fail_count = 0;
  int      due_count  = 0;
  int      results_seen = 0;

  assign mismatches  = fail_count;
  assign outstanding = due_count;

  // Lower value wins; equal values go to the lower position.
  function automatic bit beats(input logic signed [VALUE_W-1:0] va, input int pa,
                               input logic signed [VALUE_W-1:0] vb, input int pb);
    return (va < vb) || (va == vb && pa < pb);
  endfunction

  function automatic answer_t predict_answer(input logic [OPCODE_W-1:0] op,
                                             input logic signed [VALUE_W-1:0] value,
                                             input int lo, input int hi);
    answer_t                   ans;
    logic signed [VALUE_W-1:0] best_v;
    int                        best_p;
    int                        p;
    int                        j;
    int                        k;
    int                        d;
    ans.value    = '0;
    ans.position = '0;
    ans.status   = STS_OK;
    case (op)
      OP_APPEND: begin
        if (loaded >= CAPACITY) begin
          ans.status = STS_FULL;
        end else begin
          p = loaded;
          blk_min[0][p] = value;
          blk_pos[0][p] = p[POS_W-1:0];
          // Every level whose block ends at the new position gets its entry now.
          for (k = 1; k < LEVELS && (1 << k) <= p + 1; k++) begin
            j      = p + 1 - (1 << k);
            best_v = blk_min[k-1][j];
            best_p = blk_pos[k-1][j];
            if (beats(blk_min[k-1][j + (1 << (k-1))], blk_pos[k-1][j + (1 << (k-1))],
                      best_v, best_p)) begin
              best_v = blk_min[k-1][j + (1 << (k-1))];
              best_p = blk_pos[k-1][j + (1 << (k-1))];
            end
            blk_min[k][j] = best_v;
            blk_pos[k][j] = best_p[POS_W-1:0];
          end
          loaded = p + 1;
        end
      end
      OP_QUERY: begin
        if (lo >= hi) begin
          ans.status = STS_EMPTY;
        end else if (hi > loaded) begin
          ans.status = STS_PAST;
        end else begin
          // Two blocks of the largest power of two that fits cover the range.
          d = 0;
          while (d < LEVELS - 1 && (2 << d) <= hi - lo) d++;
          j      = hi - (1 << d);
          best_v = blk_min[d][lo];
          best_p = blk_pos[d][lo];
          if (beats(blk_min[d][j], blk_pos[d][j], best_v, best_p)) begin
            best_v = blk_min[d][j];
            best_p = blk_pos[d][j];
          end
          ans.value    = best_v;
          ans.position = best_p[POS_W-1:0];
        end
      end
      OP_CLEAR: loaded = 0;
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      answers_due.delete();
      loaded    = 0;
      due_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        answers_due.insert(answers_due.size(),
                           predict_answer(in_opcode, in_value, int'(in_range_start),
                                          int'(in_range_end)));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: result %0d arrived with no item waiting for it", results_seen);
          end
        end else begin
          want = answers_due.pop_front();
          if (out_min_value !== want.value || out_min_position !== want.position ||
              out_status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d: got value %0d pos %0d status %0d", results_seen,
                       out_min_value, out_min_position, out_status);
              $display("       expected value %0d pos %0d status %0d", want.value,
                       want.position, want.status);
            end
          end
        end
      end
      due_count <= answers_due.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the range-minimum engine testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module tb
  import strmq_pkg::*;
();

  localparam int CAPACITY    = 1024;
  localparam int LEVELS      = 11;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;
  localparam int ITEM_BUDGET = 1800;
  localparam int FULL_SESS   = 3;

  // The opcode field has one code that the block treats as a no-op.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic        [OPCODE_W-1:0] in_opcode      = OP_CLEAR;
  logic signed [VALUE_W-1:0]  in_value       = '0;
  logic        [START_W-1:0]  in_range_start = '0;
  logic        [END_W-1:0]    in_range_end   = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [VALUE_W-1:0]  out_min_value;
  logic        [POS_W-1:0]    out_min_position;
  logic        [STATUS_W-1:0] out_status;

  int mismatches;
  int outstanding;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int cycles         = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sparse_table_range_min_top #(
    .CAPACITY(CAPACITY),
    .LEVELS  (LEVELS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_min_position(out_min_position),
    .out_status      (out_status)
  );

  rmq_checker #(
    .CAPACITY(CAPACITY),
    .LEVELS  (LEVELS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_range_start  (in_range_start),
    .in_range_end    (in_range_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_min_value   (out_min_value),
    .out_min_position(out_min_position),
    .out_status      (out_status),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sparse_table_range_min_top verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold that backs the block up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after acceptance.
  task automatic offer(input logic [OPCODE_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                       input int lo, input int hi);
    // The idling pattern rotates every 90 items (no-ops aside) so the run sees each mix.
    case ((items_sent / 90) % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
      default: begin src_idle_pct = 21; sink_stall_pct = 21; end
    endcase
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_value       = value;
    in_range_start = lo[START_W-1:0];
    in_range_end   = hi[END_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic append_value(input logic signed [VALUE_W-1:0] value);
    offer(OP_APPEND, value, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      // A narrow spread makes equal values, and so ties, common.
      2, 3, 4, 5: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_query(input int fill);
    int lo;
    int hi;
    int pick;
    pick = $urandom_range(99);
    if (fill > 0 && pick < 80) begin
      hi = $urandom_range(fill, 1);
      if ($urandom_range(1)) lo = hi - $urandom_range(hi < 8 ? hi : 8, 1);
      else lo = $urandom_range(hi - 1, 0);
    end else if (pick < 93 && fill < CAPACITY) begin
      hi = $urandom_range(CAPACITY, fill + 1);
      lo = $urandom_range(hi - 1, 0);
    end else begin
      lo = $urandom_range(CAPACITY - 1, 0);
      hi = $urandom_range(lo, 0);
    end
    offer(OP_QUERY, $urandom, lo, hi);
  endtask

  initial begin
    int fill;
    int target;
    int sess;
    int pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty-table errors, extreme values with ties and queries, the no-op code, a clear.
    offer(OP_QUERY, '0, 0, 1);
    offer(OP_QUERY, '0, 5, 5);
    offer(OP_QUERY, '0, CAPACITY - 1, 0);
    append_value({1'b0, {(VALUE_W-1){1'b1}}});
    append_value({1'b1, {(VALUE_W-1){1'b0}}});
    append_value('0);
    append_value('1);
    append_value({1'b1, {(VALUE_W-1){1'b0}}});
    append_value(5);
    append_value(5);
    offer(OP_QUERY, '0, 0, 7);
    offer(OP_QUERY, '0, 4, 7);
    offer(OP_QUERY, '0, 5, 7);
    offer(OP_QUERY, '0, 0, 1);
    offer(OP_QUERY, '0, 2, 4);
    offer(OP_QUERY, '0, 0, 8);
    offer(OP_QUERY, '0, 3, 3);
    offer(OP_UNUSED, $urandom, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
    offer(OP_CLEAR, $urandom, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
    offer(OP_QUERY, '0, 0, 1);

    // Sessions: clear, fill to a random size amid queries, no-ops and clears, query it.
    sess = 0;
    while (items_sent < ITEM_BUDGET) begin
      if (sess == 0) hold_req = 1'b1;
      target = (sess == FULL_SESS) ? CAPACITY : $urandom_range(48, 1);
      offer(OP_CLEAR, $urandom, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
      fill = 0;
      while (fill < target) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          append_value(random_value());
          fill++;
        end else if (pick < 96) begin
          random_query(fill);
        end else if (pick < 98 || sess == FULL_SESS) begin
          offer(OP_UNUSED, $urandom, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
        end else begin
          offer(OP_CLEAR, $urandom, $urandom_range(CAPACITY - 1), $urandom_range(CAPACITY));
          fill = 0;
        end
      end
      if (fill == CAPACITY) begin
        repeat (3) append_value(random_value());
        offer(OP_QUERY, $urandom, 0, CAPACITY);
        offer(OP_QUERY, $urandom, CAPACITY - 1, CAPACITY);
      end
      repeat ($urandom_range(12, 4)) random_query(fill);
      sess++;
    end

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sparse_table_range_min_top verification clean");
    end else begin
      $display("sparse_table_range_min_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/strmq_pkg.sv
sv/strmq_ram.sv
sv/strmq_ctrl.sv
sv/strmq_dp.sv
sv/sparse_table_range_min_top.sv
tb/sv/rmq_checker.sv
tb/sv/tb.sv
